>>> design/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin package
// Shared constants and the fixed witness table.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF   = 32;
  localparam int unsigned MAX_WITNESSES_DEF = 12;
  localparam int unsigned CFG_WIDTH         = 4;
  localparam logic [CFG_WIDTH-1:0] WITNESS_COUNT_RESET = 4'd4;

  // Witness primes in order of use; each fits in six bits.
  function automatic logic [5:0] witness_prime(input logic [3:0] idx);
    logic [5:0] p;
    begin
      unique case (idx)
        4'd0:    p = 6'd2;
        4'd1:    p = 6'd3;
        4'd2:    p = 6'd5;
        4'd3:    p = 6'd7;
        4'd4:    p = 6'd11;
        4'd5:    p = 6'd13;
        4'd6:    p = 6'd17;
        4'd7:    p = 6'd19;
        4'd8:    p = 6'd23;
        4'd9:    p = 6'd29;
        4'd10:   p = 6'd31;
        4'd11:   p = 6'd37;
        default: p = 6'd37;
      endcase
      witness_prime = p;
    end
  endfunction

endpackage

>>> design/miller_rabin_prime_test.sv
// ----------------------------------------------------------------------------
// Miller-Rabin primality test
// Fixed-witness Miller-Rabin test built on one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Channel   Ports                          Handshake
// input     in_candidate                   start high while busy low
// result    out_is_prime                   out_valid high for one cycle
// config    cfg_we, cfg_witness_count      cfg_we high, written at once
//
// Every modular multiplication runs in the shared multiplier; an item takes
// up to (2*log2(n) + s) such products per witness, and trivial candidates
// (negative, below four or even) need no product at all.
// Reset is synchronous and active low; it sets witness_count to 4.
// The result cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test #(
  parameter int unsigned VALUE_WIDTH   = mrpt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_WITNESSES = mrpt_pkg::MAX_WITNESSES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [VALUE_WIDTH-1:0]   in_candidate,
  output logic                            out_valid,
  output logic                            out_is_prime,
  input  logic                            cfg_we,
  input  logic [mrpt_pkg::CFG_WIDTH-1:0]  cfg_witness_count
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned SW = $clog2(W + 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SPLIT  = 9'b000000010,
    ST_WIT    = 9'b000000100,
    ST_WMOD   = 9'b000001000,
    ST_PMUL   = 9'b000010000,
    ST_PSQR   = 9'b000100000,
    ST_CHECK  = 9'b001000000,
    ST_SQR    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t         state_r;
  logic [3:0]     wcount_r;
  logic [3:0]     limit_r, widx_r;
  logic [W-1:0]   n_r, d_r, e_r, acc_r, a_r;
  logic [SW-1:0]  s_r, r_r;
  logic           res_r, valid_r;
  logic           launched_r;

  logic           mm_go, mm_done;
  logic [W-1:0]   mm_a, mm_b, mm_prod;

  logic [3:0]     cnt_eff;
  logic [W-1:0]   nm1;

  assign nm1 = n_r - 1'b1;
  assign cnt_eff = (wcount_r == 4'd0) ? 4'd1 :
                   ((wcount_r > 4'(MAX_WITNESSES)) ? 4'(MAX_WITNESSES) : wcount_r);

  mrpt_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mm_go), .a(mm_a), .b(mm_b), .m(n_r),
    .done(mm_done), .prod(mm_prod)
  );

  always_comb begin
    mm_go = 1'b0;
    mm_a  = acc_r;
    mm_b  = a_r;
    unique case (state_r)
      ST_PMUL: begin
        mm_go = !launched_r && (e_r != '0) && e_r[0];
        mm_a  = acc_r;
        mm_b  = a_r;
      end
      ST_PSQR: begin mm_go = !launched_r; mm_a = a_r;   mm_b = a_r; end
      ST_SQR:  begin mm_go = !launched_r; mm_a = acc_r; mm_b = acc_r; end
      default: begin mm_go = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcount_r <= mrpt_pkg::WITNESS_COUNT_RESET;
    end else if (cfg_we) begin
      wcount_r <= cfg_witness_count;
    end
  end

  // The multiplier starts on the first cycle of ST_PSQR and ST_SQR, and of ST_PMUL
  // when the exponent bit is set; a flag keeps it from restarting once launched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      valid_r    <= 1'b0;
      launched_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            n_r     <= in_candidate;
            limit_r <= cnt_eff;
            widx_r  <= '0;
            if (in_candidate[W-1] || in_candidate <= $signed(W'(1))) begin
              res_r <= 1'b0; state_r <= ST_DONE;
            end else if (in_candidate <= $signed(W'(3))) begin
              res_r <= 1'b1; state_r <= ST_DONE;
            end else if (!in_candidate[0]) begin
              res_r <= 1'b0; state_r <= ST_DONE;
            end else begin
              d_r <= in_candidate - 1'b1;
              s_r <= '0;
              res_r <= 1'b1;
              state_r <= ST_SPLIT;
            end
          end
        end
        ST_SPLIT: begin
          // Strip one factor of two per cycle.
          if (!d_r[0]) begin
            d_r <= d_r >> 1;
            s_r <= s_r + 1'b1;
          end else begin
            state_r <= ST_WIT;
          end
        end
        ST_WIT: begin
          if (widx_r == limit_r) begin
            state_r <= ST_DONE;
          end else begin
            a_r   <= W'(mrpt_pkg::witness_prime(widx_r));
            state_r <= ST_WMOD;
          end
        end
        ST_WMOD: begin
          // Witnesses are below 38, so at most a few subtractions reduce them.
          if (a_r >= n_r) begin
            a_r <= a_r - n_r;
          end else if (a_r == '0) begin
            widx_r <= widx_r + 1'b1;
            state_r <= ST_WIT;
          end else begin
            acc_r   <= W'(1);
            e_r     <= d_r;
            state_r <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          if (e_r == '0) begin
            state_r <= ST_CHECK;
            r_r     <= SW'(1);
          end else if (!e_r[0]) begin
            state_r <= ST_PSQR;
          end else if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (mm_done) begin
            launched_r <= 1'b0;
            acc_r <= mm_prod;
            state_r <= ST_PSQR;
          end
        end
        ST_PSQR: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (mm_done) begin
            launched_r <= 1'b0;
            a_r <= mm_prod;
            e_r <= e_r >> 1;
            state_r <= ST_PMUL;
          end
        end
        ST_CHECK: begin
          if (acc_r == W'(1) || acc_r == nm1) begin
            widx_r <= widx_r + 1'b1;
            state_r <= ST_WIT;
          end else if (r_r >= s_r) begin
            res_r <= 1'b0;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (mm_done) begin
            launched_r <= 1'b0;
            acc_r <= mm_prod;
            r_r <= r_r + 1'b1;
            if (mm_prod == nm1) begin
              widx_r <= widx_r + 1'b1;
              state_r <= ST_WIT;
            end else if (r_r + 1'b1 >= s_r) begin
              res_r <= 1'b0;
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          valid_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = valid_r;
  assign out_is_prime = res_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> state_r == ST_IDLE)
    else $error("result shown while busy");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted without going busy");
  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WIT |-> widx_r <= limit_r)
    else $error("witness index out of range");

endmodule

>>> design/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes (a * b) mod m by scanning the bits of b from the top, one per cycle.
// ----------------------------------------------------------------------------
module mrpt_mulmod #(
  parameter int unsigned W = mrpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  a_r, m_r, b_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    dbl, dbl_red, add, add_red;

  // acc = 2*acc (+ a), each reduced by one compare-subtract as all values stay below m.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    add     = dbl_red + {1'b0, a_r};
    add_red = (add >= {1'b0, m_r}) ? add - {1'b0, m_r} : add;
    acc_nxt = b_r[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !busy_r) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiplier done while busy");
  a_result_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < m_r))
    else $error("multiplier result not reduced");
  a_count_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CW'(1)) |=> done_r)
    else $error("multiplier did not finish");

endmodule

>>> test/miller_rabin_prime_test_tb.sv
// ----------------------------------------------------------------------------
// Miller-Rabin primality test bench
// Drives candidates through the start/busy port, rewrites the witness count
// between phases and compares every verdict with a behavioural predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module miller_rabin_prime_test_tb;

  typedef struct {
    bit                             is_cfg;
    logic [mrpt_pkg::CFG_WIDTH-1:0] count;
    logic [31:0]                    cand;
  } job_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic signed [31:0]             in_candidate;
  logic                           out_valid;
  logic                           out_is_prime;
  logic                           cfg_we;
  logic [mrpt_pkg::CFG_WIDTH-1:0] cfg_witness_count;

  job_t        jobs[$];
  bit          verdicts[$];
  logic [3:0]  model_count;
  int          gap;
  int          idle_run;
  int          failures;
  int          accepted;
  int          primes_seen;
  int          settings;

  miller_rabin_prime_test dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_candidate      (in_candidate),
    .out_valid         (out_valid),
    .out_is_prime      (out_is_prime),
    .cfg_we            (cfg_we),
    .cfg_witness_count (cfg_witness_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return (a * b) % m;
  endfunction

  // Fixed-witness Miller-Rabin verdict for a 32-bit two's complement value.
  function automatic bit primality(logic [31:0] v, logic [3:0] wc);
    longint unsigned n, d, x, base, e, a;
    int s, tries;
    bit hit;
    int unsigned primes_tab[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    tries = (wc == 0) ? 1 : (wc > 12) ? 12 : wc;
    if (v[31]) return 1'b0;
    n = v;
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < tries; i++) begin
      a = primes_tab[i] % n;
      if (a == 0) continue;
      x = 1;
      base = a;
      e = d;
      while (e != 0) begin
        if (e[0]) x = mod_mul(x, base, n);
        base = mod_mul(base, base, n);
        e = e >> 1;
      end
      if (x == 1 || x == n - 1) continue;
      hit = 1'b0;
      for (int r = 1; r < s; r++) begin
        x = mod_mul(x, x, n);
        if (x == n - 1) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_item(logic [31:0] c);
    job_t j;
    j.is_cfg = 1'b0;
    j.count  = '0;
    j.cand   = c;
    jobs.push_back(j);
  endfunction

  function automatic void add_setting(logic [3:0] c);
    job_t j;
    j.is_cfg = 1'b1;
    j.count  = c;
    j.cand   = '0;
    jobs.push_back(j);
  endfunction

  function automatic logic [31:0] random_candidate();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom_range(0, 1000);
    if (pick < 65) return {16'h0, 16'($urandom)} | 32'd1;
    if (pick < 85) return $urandom;
    return {1'b0, 31'($urandom)} | 32'd1;
  endfunction

  // Driver: a configuration write waits until the block has gone quiet.
  always @(posedge clk) begin
    job_t head;
    logic next_we;
    next_we = 1'b0;
    if (!rst_n) begin
      start    <= 1'b0;
      gap      <= 0;
      idle_run <= 0;
    end else begin
      idle_run <= (verdicts.size() == 0 && !busy && !start) ? idle_run + 1 : 0;
      if (start) begin
        if (!busy) begin
          verdicts.push_back(primality(in_candidate, model_count));
          accepted++;
          start <= 1'b0;
          gap   <= $urandom_range(0, 12);
        end
      end else if (gap != 0) begin
        gap <= gap - 1;
      end else if (jobs.size() != 0) begin
        head = jobs[0];
        if (head.is_cfg) begin
          if (idle_run >= 4) begin
            next_we = 1'b1;
            cfg_witness_count <= head.count;
            model_count = head.count;
            settings++;
            void'(jobs.pop_front());
          end
        end else begin
          start        <= 1'b1;
          in_candidate <= head.cand;
          void'(jobs.pop_front());
        end
      end
    end
    cfg_we <= next_we;
  end

  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid) begin
      if (verdicts.size() == 0) begin
        $error("is_prime: result with none expected, actual %0b", out_is_prime);
        failures++;
      end else begin
        want = verdicts.pop_front();
        if (out_is_prime !== want) begin
          $error("is_prime: expected %0b, actual %0b", want, out_is_prime);
          failures++;
        end
        if (want) primes_seen++;
      end
    end
  end

  initial begin
    logic [31:0] directed[] = '{32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 2, 3, 4, 5, 9, 25,
                                32'h7FFF_FFFF, 32'h7FFF_FFFE, 2047, 1373653,
                                25326001, 561, 7919};
    failures     = 0;
    accepted     = 0;
    primes_seen  = 0;
    settings     = 0;
    model_count  = mrpt_pkg::WITNESS_COUNT_RESET;
    rst_n        = 1'b0;
    start        = 1'b0;
    cfg_we       = 1'b0;
    in_candidate = '0;
    cfg_witness_count = mrpt_pkg::WITNESS_COUNT_RESET;

    foreach (directed[i]) add_item(directed[i]);
    // One witness lets the base-2 strong pseudoprime through.
    add_setting(4'd1);
    add_item(2047);
    add_item(1373653);
    add_item(7);
    // Count zero behaves as one; large counts saturate and skip witnesses n divides.
    add_setting(4'd0);
    add_item(2047);
    add_setting(4'd15);
    add_item(5);
    add_item(37);
    add_item(25326001);
    add_setting(4'd12);
    add_item(11);
    add_item(32'd3215031751 & 32'h7FFF_FFFF);
    for (int p = 0; p < 10; p++) begin
      add_setting(4'($urandom_range(0, 15)));
      for (int k = 0; k < 30; k++) add_item(random_candidate());
    end
    add_setting(4'd4);
    add_item(2147483647);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (jobs.size() != 0 || start || verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Checked %0d candidates (%0d judged prime) over %0d witness-count settings.",
             accepted, primes_seen, settings);
    if (failures == 0 && verdicts.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
